// File: sv/grm_pkg.sv
// Shared types, codes and constants of the grid ray-march distance unit.
`timescale 1ns / 1ps
package grm_pkg;

  // Item operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEPS = 2'd1;

  // Register widths and reset values
  localparam int unsigned STEP_W   = 14;
  localparam int unsigned MAXS_W   = 10;
  localparam int unsigned CFG_DATA_W = 14;
  localparam logic [STEP_W-1:0] STEP_SIZE_RST = 14'd655;
  localparam logic [MAXS_W-1:0] MAX_STEPS_RST = 10'd400;

  // Field widths
  localparam int unsigned CELL_IO_W = 4;
  localparam int unsigned ORIGIN_W  = 20;
  localparam int unsigned ANGLE_W   = 16;
  localparam int unsigned DIST_W    = 23;
  localparam int unsigned COUNT_W   = 11;

  // Datapath number formats
  localparam int unsigned FRAC_W  = 32;            // position fraction bits
  localparam int unsigned POS_W   = 43;            // signed position
  localparam int unsigned CELL_W  = POS_W - FRAC_W; // signed cell index
  localparam int unsigned QVAL_W  = 17;            // quarter-wave value, one = 2^16
  localparam int unsigned DELTA_W = 32;            // signed per-step increment
  localparam int unsigned PROD_W  = 25;            // steps * step size
  localparam logic [QVAL_W-1:0] QVAL_ONE = 17'h10000;
  localparam logic [15:0] QUARTER_TURN = 16'd16384;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_wr;   // clearing pass writes one map cell
    logic load;     // item accepted
    logic rom_rd;   // quarter-wave table read
    logic rom_cos;  // table read is for the cosine
    logic mul_sin;  // scale sine into the y increment
    logic mul_cos;  // scale cosine into x increment, load origin
    logic advance;  // issue map read for current point and step forward
    logic check;    // test the point issued in the cycle before
    logic finish;   // compute distance and present the result
  } grm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last; // clearing pass at its last cell
    logic stop;     // march ends at the checked point
  } grm_stat_t;

  // Quarter-wave sine entry k of a 2^tw table, integer Taylor series in Q2.30.
  // Evaluated at elaboration only.
  function automatic logic [15:0] sine_entry(input int unsigned k, input int unsigned tw);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] r;
    x    = (HALF_PI_Q30 * 64'(k)) >> tw;
    term = x;
    pos  = x;
    neg  = 64'd0;
    term = (term * x) >> 30; term = (term * x) >> 30; term = term / 64'd6;   neg = neg + term;
    term = (term * x) >> 30; term = (term * x) >> 30; term = term / 64'd20;  pos = pos + term;
    term = (term * x) >> 30; term = (term * x) >> 30; term = term / 64'd42;  neg = neg + term;
    term = (term * x) >> 30; term = (term * x) >> 30; term = term / 64'd72;  pos = pos + term;
    term = (term * x) >> 30; term = (term * x) >> 30; term = term / 64'd110; neg = neg + term;
    term = (term * x) >> 30; term = (term * x) >> 30; term = term / 64'd156; pos = pos + term;
    r = (pos > neg) ? (pos - neg) : 64'd0;
    r = (r + 64'd8192) >> 14;
    if (r > 64'd65535) begin
      r = 64'd65535;
    end
    return r[15:0];
  endfunction

endpackage

// File: sv/grm_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module grm_ram #(
  parameter int DATA_W = 1,
  parameter int DEPTH  = 256
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [DATA_W-1:0]        wdata_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // read first (a write returns the old data), read registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/grm_ctrl.sv
// Sequencer of the grid ray-march unit: clearing pass, table setup, march, result.
`timescale 1ns / 1ps
module grm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                operation_i,
  input  grm_pkg::grm_stat_t  stat_i,
  output grm_pkg::grm_cmd_t   cmd_o,
  output logic                busy_o
);
  import grm_pkg::*;

  typedef enum logic [7:0] {
    ST_CLEAR    = 8'b0000_0001,
    ST_IDLE     = 8'b0000_0010,
    ST_TRIG_SIN = 8'b0000_0100,
    ST_TRIG_COS = 8'b0000_1000,
    ST_MUL_COS  = 8'b0001_0000,
    ST_ISSUE    = 8'b0010_0000,
    ST_MARCH    = 8'b0100_0000,
    ST_FINISH   = 8'b1000_0000
  } state_e;

  state_e st_q, st_d;

  // next state and commands
  always_comb begin
    st_d  = st_q;
    cmd_o = '0;
    case (st_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (operation_i == OP_CAST) begin
            st_d = ST_TRIG_SIN;
          end
        end
      end
      ST_TRIG_SIN: begin
        cmd_o.rom_rd = 1'b1;
        st_d = ST_TRIG_COS;
      end
      ST_TRIG_COS: begin
        cmd_o.rom_rd  = 1'b1;
        cmd_o.rom_cos = 1'b1;
        cmd_o.mul_sin = 1'b1;
        st_d = ST_MUL_COS;
      end
      ST_MUL_COS: begin
        cmd_o.mul_cos = 1'b1;
        st_d = ST_ISSUE;
      end
      ST_ISSUE: begin
        cmd_o.advance = 1'b1;
        st_d = ST_MARCH;
      end
      ST_MARCH: begin
        cmd_o.advance = 1'b1;
        cmd_o.check   = 1'b1;
        if (stat_i.stop) begin
          st_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        st_d = ST_IDLE;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLEAR;
    end else begin
      st_q <= st_d;
    end
  end

  assign busy_o = (st_q != ST_IDLE);

endmodule

// File: sv/grm_datapath.sv
// Datapath of the grid ray-march unit: sine table, step scaling, march, wall map.
`timescale 1ns / 1ps
module grm_datapath #(
  parameter int MAP_SIDE         = 16,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  grm_pkg::grm_cmd_t                   cmd_i,
  output grm_pkg::grm_stat_t                  stat_o,
  input  logic                                operation_i,
  input  logic [grm_pkg::CELL_IO_W-1:0]       cell_x_i,
  input  logic [grm_pkg::CELL_IO_W-1:0]       cell_y_i,
  input  logic                                cell_wall_i,
  input  logic [grm_pkg::ORIGIN_W-1:0]        origin_x_i,
  input  logic [grm_pkg::ORIGIN_W-1:0]        origin_y_i,
  input  logic [grm_pkg::ANGLE_W-1:0]         angle_i,
  input  logic [grm_pkg::STEP_W-1:0]          step_size_i,
  input  logic [grm_pkg::MAXS_W-1:0]          max_steps_i,
  output logic [grm_pkg::DIST_W-1:0]          distance_o,
  output logic [grm_pkg::COUNT_W-1:0]         step_count_o,
  output logic                                hit_wall_o,
  output logic [grm_pkg::CELL_IO_W-1:0]       hit_col_o,
  output logic [grm_pkg::CELL_IO_W-1:0]       hit_row_o,
  output logic                                done_o
);
  import grm_pkg::*;

  localparam int NCELL = MAP_SIDE * MAP_SIDE;
  localparam int AW    = $clog2(NCELL);
  localparam int XW    = $clog2(MAP_SIDE);
  localparam int TW    = $clog2(SINE_TABLE_DEPTH);

  // ---------------------------------------------------------------- item latch
  logic [ORIGIN_W-1:0] org_x_q, org_y_q;
  logic [ANGLE_W-1:0]  angle_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      org_x_q <= origin_x_i;
      org_y_q <= origin_y_i;
      angle_q <= angle_i;
    end
  end

  // ---------------------------------------------------------------- sine table
  logic [15:0] rom [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [15:0] ENTRY = sine_entry(k, TW);
    assign rom[k] = ENTRY;
  end

  logic [ANGLE_W-1:0] rd_angle;
  logic [1:0]         rd_quad;
  logic [TW-1:0]      rd_idx;
  logic [TW:0]        rd_j;
  logic [QVAL_W-1:0]  qval_q;
  logic               neg_q;

  // cosine reads the angle a quarter turn ahead; odd quadrants mirror the index
  assign rd_angle = cmd_i.rom_cos ? (angle_q + QUARTER_TURN) : angle_q;
  assign rd_quad  = rd_angle[15:14];
  assign rd_idx   = rd_angle[13 -: TW];
  assign rd_j     = rd_quad[0] ? ((TW+1)'(SINE_TABLE_DEPTH) - {1'b0, rd_idx})
                               : {1'b0, rd_idx};

  always_ff @(posedge clk_i) begin
    if (cmd_i.rom_rd) begin
      qval_q <= rd_j[TW] ? QVAL_ONE : {1'b0, rom[rd_j[TW-1:0]]};
      neg_q  <= rd_quad[1];
    end
  end

  // ---------------------------------------------------------------- step scaling
  logic signed [QVAL_W:0]    sval;
  logic signed [DELTA_W:0]   prod;
  logic signed [DELTA_W-1:0] dx_q, dy_q;

  assign sval = neg_q ? -$signed({1'b0, qval_q}) : $signed({1'b0, qval_q});
  assign prod = sval * $signed({1'b0, step_size_i});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_sin) begin
      dy_q <= prod[DELTA_W-1:0];
    end
    if (cmd_i.mul_cos) begin
      dx_q <= prod[DELTA_W-1:0];
    end
  end

  // ---------------------------------------------------------------- march point
  logic signed [POS_W-1:0] px_q, py_q;
  logic [COUNT_W-1:0]      cnt_q;
  logic [CELL_W-1:0]       cx, cy;
  logic                    oob;
  logic [AW-1:0]           march_addr;

  assign cx  = px_q[POS_W-1:FRAC_W];
  assign cy  = py_q[POS_W-1:FRAC_W];
  // negative index or index at or beyond the map side counts as wall
  assign oob = cx[CELL_W-1] | cy[CELL_W-1]
             | (cx >= CELL_W'(MAP_SIDE)) | (cy >= CELL_W'(MAP_SIDE));
  assign march_addr = AW'(AW'(cy[XW-1:0]) * AW'(MAP_SIDE)) + AW'(cx[XW-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_cos) begin
      px_q  <= POS_W'({org_x_q, 16'h0000});
      py_q  <= POS_W'({org_y_q, 16'h0000});
      cnt_q <= '0;
    end else if (cmd_i.advance) begin
      px_q  <= px_q + POS_W'(dx_q);
      py_q  <= py_q + POS_W'(dy_q);
      cnt_q <= cnt_q + COUNT_W'(1);
    end
  end

  // check stage: point issued last cycle, its map bit now out of the RAM
  logic [COUNT_W-1:0]   chk_k_q;
  logic                 chk_oob_q;
  logic [CELL_IO_W-1:0] chk_cx_q, chk_cy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.advance) begin
      chk_k_q   <= cnt_q;
      chk_oob_q <= oob;
      chk_cx_q  <= cx[CELL_IO_W-1:0];
      chk_cy_q  <= cy[CELL_IO_W-1:0];
    end
  end

  // ---------------------------------------------------------------- wall map
  logic [AW-1:0] clr_cnt_q;
  logic [AW-1:0] wr_addr;
  logic          wr_in_map;
  logic [AW-1:0] ram_addr;
  logic          ram_we;
  logic          ram_wd;
  logic [0:0]    ram_rd;

  assign wr_addr   = AW'(AW'(cell_y_i) * AW'(MAP_SIDE)) + AW'(cell_x_i);
  assign wr_in_map = (7'(cell_x_i) < 7'(MAP_SIDE)) && (7'(cell_y_i) < 7'(MAP_SIDE));

  always_comb begin
    if (cmd_i.clr_wr) begin
      ram_addr = clr_cnt_q;
      ram_we   = 1'b1;
      ram_wd   = 1'b0;
    end else if (cmd_i.load) begin
      ram_addr = wr_addr;
      ram_we   = (operation_i == OP_WRITE) && wr_in_map;
      ram_wd   = cell_wall_i;
    end else begin
      ram_addr = march_addr;
      ram_we   = 1'b0;
      ram_wd   = 1'b0;
    end
  end

  // clearing pass address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  grm_ram #(
    .DATA_W (1),
    .DEPTH  (NCELL)
  ) u_map (
    .clk_i   (clk_i),
    .addr_i  (ram_addr),
    .we_i    (ram_we),
    .wdata_i (ram_wd),
    .rdata_o (ram_rd)
  );

  // ---------------------------------------------------------------- stop test
  logic wall, limit;

  assign wall  = chk_oob_q | ram_rd[0];
  // limit: the step after the checked point is already in px/py and cnt
  assign limit = (cnt_q > {1'b0, max_steps_i});

  assign stat_o.clr_last = (clr_cnt_q == AW'(NCELL - 1));
  assign stat_o.stop     = wall | limit;

  logic [COUNT_W-1:0]   res_steps_q;
  logic                 res_hit_q;
  logic [CELL_IO_W-1:0] res_col_q, res_row_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      if (wall) begin
        res_steps_q <= chk_k_q;
        res_hit_q   <= 1'b1;
        res_col_q   <= chk_cx_q;
        res_row_q   <= chk_cy_q;
      end else begin
        res_steps_q <= cnt_q;
        res_hit_q   <= 1'b0;
        res_col_q   <= cx[CELL_IO_W-1:0];
        res_row_q   <= cy[CELL_IO_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- result
  logic [PROD_W-1:0] dist_full;
  logic [DIST_W-1:0] dist_q;
  logic [COUNT_W-1:0] out_steps_q;
  logic              out_hit_q;
  logic [CELL_IO_W-1:0] out_col_q, out_row_q;
  logic              done_q;

  assign dist_full = PROD_W'(res_steps_q) * PROD_W'(step_size_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      dist_q      <= (|dist_full[PROD_W-1:DIST_W]) ? {DIST_W{1'b1}} : dist_full[DIST_W-1:0];
      out_steps_q <= res_steps_q;
      out_hit_q   <= res_hit_q;
      out_col_q   <= res_col_q;
      out_row_q   <= res_row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  assign distance_o   = dist_q;
  assign step_count_o = out_steps_q;
  assign hit_wall_o   = out_hit_q;
  assign hit_col_o    = out_col_q;
  assign hit_row_o    = out_row_q;
  assign done_o       = done_q;

  // a checked point must have been issued the cycle before
  a_check_after_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.check |-> $past(cmd_i.advance))
    else $error("march check without a preceding map read");

endmodule

// File: sv/grid_ray_march_distance.sv
// Top level of the grid ray-march distance unit: registers, sequencer and datapath.
`timescale 1ns / 1ps
// Grid ray-march distance unit.
// Items enter on start_i while busy_o is low. operation_i = 0 writes one
// wall bit of the map (cell_x_i, cell_y_i, cell_wall_i); it is done in the
// accepting cycle, gives no result, and the next item may follow at once.
// operation_i = 1 casts a ray from origin_x_i/origin_y_i (Q4.16 cells) at
// angle_i. The block looks up sine and cosine in a quarter-wave table,
// scales them by step_size, then walks the point one step per cycle,
// reading one map bit per cycle from a single-port RAM. A cast keeps
// busy_o high from its table reads through the march to the result; the
// march ends when a wall or the map edge stops it or at the step limit.
// The result is shown on distance_o, step_count_o, hit_wall_o, hit_col_o,
// hit_row_o for exactly one cycle with done_o high, in the cycle busy_o
// falls; the receiver cannot stall it.
// Registers are written over cfg_valid_i/cfg_ready_o with cfg_index_i and
// cfg_data_i (index 0 step_size, 1 max_steps) by the user only while the
// block is idle, which the block itself does not enforce. After reset a
// clearing pass writes every map cell open, one a cycle, with busy_o high.
module grid_ray_march_distance #(
  parameter int MAP_SIDE         = 16,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              operation_i,
  input  logic [grm_pkg::CELL_IO_W-1:0]     cell_x_i,
  input  logic [grm_pkg::CELL_IO_W-1:0]     cell_y_i,
  input  logic                              cell_wall_i,
  input  logic [grm_pkg::ORIGIN_W-1:0]      origin_x_i,
  input  logic [grm_pkg::ORIGIN_W-1:0]      origin_y_i,
  input  logic [grm_pkg::ANGLE_W-1:0]       angle_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [grm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [grm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                              done_o,
  output logic [grm_pkg::DIST_W-1:0]        distance_o,
  output logic [grm_pkg::COUNT_W-1:0]       step_count_o,
  output logic                              hit_wall_o,
  output logic [grm_pkg::CELL_IO_W-1:0]     hit_col_o,
  output logic [grm_pkg::CELL_IO_W-1:0]     hit_row_o
);
  import grm_pkg::*;

  // configuration registers
  logic [STEP_W-1:0] step_size_q;
  logic [MAXS_W-1:0] max_steps_q;
  logic              cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_size_q <= STEP_SIZE_RST;
      max_steps_q <= MAX_STEPS_RST;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        REG_STEP_SIZE: step_size_q <= cfg_data_i[STEP_W-1:0];
        REG_MAX_STEPS: max_steps_q <= cfg_data_i[MAXS_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath
  grm_cmd_t  cmd;
  grm_stat_t stat;

  grm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy_o      (busy_o)
  );

  grm_datapath #(
    .MAP_SIDE         (MAP_SIDE),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .operation_i  (operation_i),
    .cell_x_i     (cell_x_i),
    .cell_y_i     (cell_y_i),
    .cell_wall_i  (cell_wall_i),
    .origin_x_i   (origin_x_i),
    .origin_y_i   (origin_y_i),
    .angle_i      (angle_i),
    .step_size_i  (step_size_q),
    .max_steps_i  (max_steps_q),
    .distance_o   (distance_o),
    .step_count_o (step_count_o),
    .hit_wall_o   (hit_wall_o),
    .hit_col_o    (hit_col_o),
    .hit_row_o    (hit_row_o),
    .done_o       (done_o)
  );

  // a result only closes a cast that kept the block busy
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result without a cast in progress");

  // the step count never exceeds the step limit plus one
  a_steps_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (step_count_o <= ({1'b0, max_steps_q} + COUNT_W'(1))))
    else $error("step count beyond the limit");

  // zero steps only when the origin cell is a wall
  a_zero_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (step_count_o == '0)) |-> (hit_wall_o && (distance_o == '0)))
    else $error("zero-step result without a wall hit");

endmodule

// File: tb/grm_checker.sv
// Checker for the grid ray-march unit: tracks map and registers, predicts each ray, compares.
`timescale 1ns / 1ps
module grm_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  logic                           operation_i,
  input  logic [grm_pkg::CELL_IO_W-1:0]  cell_x_i,
  input  logic [grm_pkg::CELL_IO_W-1:0]  cell_y_i,
  input  logic                           cell_wall_i,
  input  logic [grm_pkg::ORIGIN_W-1:0]   origin_x_i,
  input  logic [grm_pkg::ORIGIN_W-1:0]   origin_y_i,
  input  logic [grm_pkg::ANGLE_W-1:0]    angle_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [grm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [grm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           done_i,
  input  logic [grm_pkg::DIST_W-1:0]     distance_i,
  input  logic [grm_pkg::COUNT_W-1:0]    step_count_i,
  input  logic                           hit_wall_i,
  input  logic [grm_pkg::CELL_IO_W-1:0]  hit_col_i,
  input  logic [grm_pkg::CELL_IO_W-1:0]  hit_row_i,
  output int                             fail_count_o,
  output int                             rays_pending_o,
  output int                             wall_stops_o,
  output int                             limit_stops_o
);
  import grm_pkg::*;

  localparam int SIDE      = 16;
  localparam int DEPTH     = 1024;
  localparam int SHOWN_MAX = 10;
  localparam longint unsigned DIST_SAT = 64'd8388607;

  typedef struct packed {
    logic [DIST_W-1:0]    distance;
    logic [COUNT_W-1:0]   steps;
    logic                 hit;
    logic [CELL_IO_W-1:0] col;
    logic [CELL_IO_W-1:0] row;
  } ray_result_t;

  logic [15:0]       quarter_wave [DEPTH];
  logic              wall_bits [SIDE*SIDE];
  logic [STEP_W-1:0] step_reg;
  logic [MAXS_W-1:0] limit_reg;
  ray_result_t       expected_rays [$];
  int                fails;
  int                wall_stops;
  int                limit_stops;

  // Quarter-wave entry k: sin(pi/2 * k / DEPTH) in Q16, Taylor series in Q2.30
  function automatic logic [15:0] taylor_sine(input int unsigned k);
    longint unsigned x;
    longint unsigned term;
    longint unsigned pos_sum;
    longint unsigned neg_sum;
    longint unsigned r;
    int n;
    x = (HALF_PI_Q30 * longint'(k)) / DEPTH;
    term = x;
    pos_sum = x;
    neg_sum = 0;
    for (n = 1; n <= 6; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) neg_sum += term;
      else pos_sum += term;
    end
    r = (pos_sum > neg_sum) ? pos_sum - neg_sum : 0;
    r = (r + 64'd8192) >> 14;
    if (r > 64'd65535) r = 64'd65535;
    return r[15:0];
  endfunction

  // Table read where the top index stands for exactly one
  function automatic longint quarter_val(input int unsigned j);
    if (j >= DEPTH) return 65536;
    return longint'(quarter_wave[j]);
  endfunction

  // Signed Q1.16 sine of a binary angle
  function automatic longint sine_val(input logic [15:0] a);
    int unsigned idx;
    longint v;
    idx = (int'(a[13:0]) * DEPTH) >> 14;
    v = a[14] ? quarter_val(DEPTH - idx) : quarter_val(idx);
    return a[15] ? -v : v;
  endfunction

  // Cells off the map are solid
  function automatic logic cell_blocked(input longint cx, input longint cy);
    if (cx < 0 || cy < 0 || cx >= SIDE || cy >= SIDE) return 1'b1;
    return wall_bits[cy * SIDE + cx];
  endfunction

  // Walk one ray through the current map with the current registers
  function automatic ray_result_t march_ray(input logic [19:0] ox, input logic [19:0] oy,
                                            input logic [15:0] ang);
    logic [15:0] cos_ang;
    longint dx, dy, px, py, cx, cy;
    longint unsigned dist_val;
    int unsigned steps;
    logic hit;
    ray_result_t res;
    cos_ang = ang + QUARTER_TURN;
    dy = sine_val(ang) * longint'(step_reg);
    dx = sine_val(cos_ang) * longint'(step_reg);
    px = longint'({ox, 16'h0000});
    py = longint'({oy, 16'h0000});
    steps = 0;
    hit = 1'b0;
    forever begin
      cx = px >>> FRAC_W;
      cy = py >>> FRAC_W;
      if (cell_blocked(cx, cy)) begin
        hit = 1'b1;
        break;
      end
      px += dx;
      py += dy;
      steps++;
      // last step is not looked up in the map
      if (steps > limit_reg) begin
        cx = px >>> FRAC_W;
        cy = py >>> FRAC_W;
        break;
      end
    end
    dist_val = longint'(steps) * longint'(step_reg);
    if (dist_val > DIST_SAT) dist_val = DIST_SAT;
    res.distance = dist_val[DIST_W-1:0];
    res.steps    = steps[COUNT_W-1:0];
    res.hit      = hit;
    res.col      = cx[CELL_IO_W-1:0];
    res.row      = cy[CELL_IO_W-1:0];
    return res;
  endfunction

  initial begin
    for (int k = 0; k < DEPTH; k++) quarter_wave[k] = taylor_sine(k);
  end

  // Compare results, track register writes and items
  always @(posedge clk_i or negedge rst_ni) begin
    ray_result_t want;
    if (!rst_ni) begin
      for (int c = 0; c < SIDE * SIDE; c++) wall_bits[c] = 1'b0;
      step_reg = STEP_SIZE_RST;
      limit_reg = MAX_STEPS_RST;
      expected_rays.delete();
      fails = 0;
      wall_stops = 0;
      limit_stops = 0;
    end else begin
      if (done_i) begin
        if (hit_wall_i) wall_stops++;
        else limit_stops++;
        if (expected_rays.size() == 0) begin
          if (fails < SHOWN_MAX)
            $display("ERROR unexpected ray result at %0t: dist=%0d steps=%0d hit=%0d",
                     $realtime, distance_i, step_count_i, hit_wall_i);
          fails++;
        end else begin
          want = expected_rays.pop_front();
          if (want.distance !== distance_i || want.steps !== step_count_i ||
              want.hit !== hit_wall_i || want.col !== hit_col_i || want.row !== hit_row_i) begin
            if (fails < SHOWN_MAX) begin
              $display("ERROR ray mismatch at %0t", $realtime);
              $display("  expected dist=%0d steps=%0d hit=%0d cell=(%0d,%0d)",
                       want.distance, want.steps, want.hit, want.col, want.row);
              $display("  actual   dist=%0d steps=%0d hit=%0d cell=(%0d,%0d)",
                       distance_i, step_count_i, hit_wall_i, hit_col_i, hit_row_i);
            end
            fails++;
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_STEP_SIZE: step_reg = cfg_data_i[STEP_W-1:0];
          REG_MAX_STEPS: limit_reg = cfg_data_i[MAXS_W-1:0];
          default: ;
        endcase
      end

      if (start_i && !busy_i) begin
        if (operation_i == OP_WRITE) wall_bits[{cell_y_i, cell_x_i}] = cell_wall_i;
        else expected_rays.push_back(march_ray(origin_x_i, origin_y_i, angle_i));
      end
    end
    fail_count_o   <= fails;
    rays_pending_o <= expected_rays.size();
    wall_stops_o   <= wall_stops;
    limit_stops_o  <= limit_stops;
  end

endmodule

// File: tb/tb.sv
// Testbench top for the grid ray-march unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
  import grm_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 2000000;
  localparam int          SETTLE_CYCLES   = 12;
  localparam int          RANDOM_PHASES   = 8;
  localparam int          ITEMS_PER_PHASE = 56;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam logic [ORIGIN_W-1:0]  MID_CELL    = 20'h88000;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  operation;
  logic [CELL_IO_W-1:0]  cell_x;
  logic [CELL_IO_W-1:0]  cell_y;
  logic                  cell_wall;
  logic [ORIGIN_W-1:0]   origin_x;
  logic [ORIGIN_W-1:0]   origin_y;
  logic [ANGLE_W-1:0]    angle;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  done;
  logic [DIST_W-1:0]     distance;
  logic [COUNT_W-1:0]    step_count;
  logic                  hit_wall;
  logic [CELL_IO_W-1:0]  hit_col;
  logic [CELL_IO_W-1:0]  hit_row;

  int          fail_count;
  int          rays_pending;
  int          wall_stops;
  int          limit_stops;
  int unsigned cycle_count;
  int          gap_ceiling;
  int          casts_sent;
  int          writes_sent;
  int          settings_used;

  grid_ray_march_distance dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_o       (busy),
    .operation_i  (operation),
    .cell_x_i     (cell_x),
    .cell_y_i     (cell_y),
    .cell_wall_i  (cell_wall),
    .origin_x_i   (origin_x),
    .origin_y_i   (origin_y),
    .angle_i      (angle),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .done_o       (done),
    .distance_o   (distance),
    .step_count_o (step_count),
    .hit_wall_o   (hit_wall),
    .hit_col_o    (hit_col),
    .hit_row_o    (hit_row)
  );

  grm_checker ray_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .operation_i    (operation),
    .cell_x_i       (cell_x),
    .cell_y_i       (cell_y),
    .cell_wall_i    (cell_wall),
    .origin_x_i     (origin_x),
    .origin_y_i     (origin_y),
    .angle_i        (angle),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .done_i         (done),
    .distance_i     (distance),
    .step_count_i   (step_count),
    .hit_wall_i     (hit_wall),
    .hit_col_i      (hit_col),
    .hit_row_i      (hit_row),
    .fail_count_o   (fail_count),
    .rays_pending_o (rays_pending),
    .wall_stops_o   (wall_stops),
    .limit_stops_o  (limit_stops)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d rays outstanding", cycle_count, rays_pending);
      $display("FAILURE");
      $finish;
    end
  end

  // One item; holds start until accepted, then drops start for a random gap up to gap_ceiling
  task automatic send_item(input logic op, input logic [3:0] cx, input logic [3:0] cy,
                           input logic w, input logic [19:0] ox, input logic [19:0] oy,
                           input logic [15:0] ang);
    int gap;
    gap = $urandom_range(0, gap_ceiling);
    @(negedge clk);
    operation = op;
    cell_x    = cx;
    cell_y    = cy;
    cell_wall = w;
    origin_x  = ox;
    origin_y  = oy;
    angle     = ang;
    start     = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == OP_CAST) casts_sent++;
    else writes_sent++;
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic put_cell(input logic [3:0] cx, input logic [3:0] cy, input logic w);
    send_item(OP_WRITE, cx, cy, w, 20'($urandom), 20'($urandom), 16'($urandom));
  endtask

  task automatic cast_ray(input logic [19:0] ox, input logic [19:0] oy, input logic [15:0] ang);
    send_item(OP_CAST, 4'($urandom), 4'($urandom), 1'($urandom), ox, oy, ang);
  endtask

  // Stop sending and let every outstanding ray come back
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (rays_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mostly in-map casts with random content, some map writes
  task automatic random_item(input int wall_pct);
    logic [19:0] ox;
    logic [19:0] oy;
    logic [15:0] ang;
    ox  = 20'($urandom);
    oy  = 20'($urandom);
    ang = 16'($urandom);
    // origins on cell edges
    if ($urandom_range(0, 4) == 0) begin
      ox[15:0] = ($urandom_range(0, 1) == 1) ? 16'h0000 : 16'hFFFF;
      oy[15:0] = ($urandom_range(0, 1) == 1) ? 16'h0000 : 16'hFFFF;
    end
    // angles at and next to the axes and diagonals
    if ($urandom_range(0, 3) == 0)
      ang = 16'($urandom_range(0, 7) * 8192 + $urandom_range(0, 2) - 1);
    if ($urandom_range(0, 9) < 3)
      send_item(OP_WRITE, 4'($urandom), 4'($urandom), $urandom_range(0, 99) < wall_pct,
                ox, oy, ang);
    else
      send_item(OP_CAST, 4'($urandom), 4'($urandom), 1'($urandom), ox, oy, ang);
  endtask

  // Stimulus
  initial begin
    int step_val;
    int max_val;
    int wall_pct;
    rst_n = 1'b0;
    start = 1'b0;
    operation = OP_WRITE;
    cell_x = '0;
    cell_y = '0;
    cell_wall = 1'b0;
    origin_x = '0;
    origin_y = '0;
    angle = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_STEP_SIZE;
    cfg_data = '0;
    gap_ceiling = 7;
    casts_sent = 0;
    writes_sent = 0;
    settings_used = 1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: walls at corners, wall at the origin, every way off the map
    put_cell(4'd0, 4'd0, 1'b1);
    put_cell(4'd15, 4'd15, 1'b1);
    put_cell(4'd15, 4'd0, 1'b1);
    put_cell(4'd15, 4'd0, 1'b0);
    cast_ray(20'h00000, 20'h00000, 16'd0);
    cast_ray(MID_CELL, MID_CELL, 16'd0);
    cast_ray(MID_CELL, MID_CELL, 16'd16384);
    cast_ray(MID_CELL, MID_CELL, 16'd32768);
    cast_ray(MID_CELL, MID_CELL, 16'd49152);
    cast_ray(MID_CELL, MID_CELL, 16'd65535);
    cast_ray(MID_CELL, MID_CELL, 16'd8192);
    cast_ray(20'hFFFFF, 20'hFFFFF, 16'd32768);
    cast_ray(20'hFFFFF, 20'h00000, 16'd0);
    cast_ray(20'h00000, 20'h80000, 16'd32768);
    cast_ray(20'h80000, 20'h00000, 16'd49152);
    cast_ray(20'h80000, 20'hFFFFF, 16'd16384);
    cast_ray(20'h10000, 20'h10000, 16'd40960);
    cast_ray(20'h0FFFF, 20'h0FFFF, 16'd24576);

    // Random phases, each under its own register setting and wall density
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      case (phase)
        0: begin step_val = 0;     max_val = 400;  end
        1: begin step_val = 655;   max_val = 0;    end
        2: begin step_val = 8192;  max_val = 1023; end
        3: begin step_val = 1;     max_val = 1023; end
        4: begin step_val = 16383; max_val = 1;    end
        5: begin step_val = 655;   max_val = 400;  end
        default: begin
          step_val = $urandom_range(1, 8192);
          max_val  = $urandom_range(1, 1023);
        end
      endcase
      write_reg(REG_STEP_SIZE, CFG_DATA_W'(step_val));
      // upper data bits land outside the limit register
      write_reg(REG_MAX_STEPS, {4'($urandom), 10'(max_val)});
      write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_2 : REG_SPARE_3,
                CFG_DATA_W'($urandom));
      settings_used++;
      wall_pct = $urandom_range(5, 50);
      gap_ceiling = (phase % 3 == 2) ? 0 : 7;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        random_item(wall_pct);
        if ($urandom_range(0, 39) == 0) drain();
      end
    end

    drain();
    $display("Sent %0d items: %0d ray casts and %0d map writes, under %0d register settings.",
             casts_sent + writes_sent, casts_sent, writes_sent, settings_used);
    $display("Rays ended on a wall or map edge %0d times and on the step limit %0d times.",
             wall_stops, limit_stops);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d ray results were wrong or unexpected", fail_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
